/* rtl/core/ple_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    localparam int POS_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_AT    = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [2:0] CMD_DEL_AT    = 3'd5;
    localparam logic [2:0] CMD_READ      = 3'd6;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_IGNORED    = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY_READ = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   last;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/ple_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ple_cell #(
    parameter int IDX = 0
) (
    input  wire logic                       aclk,
    input  wire ple_pkg::cell_ctrl_t        ctrl,
    input  wire logic [ple_pkg::DATA_W-1:0] ins_value,
    input  wire logic [ple_pkg::DATA_W-1:0] left_data,
    input  wire logic [ple_pkg::DATA_W-1:0] right_data,
    input  wire logic [ple_pkg::DATA_W-1:0] head_data,
    output logic [ple_pkg::DATA_W-1:0]      data
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            OP_INS: begin
                if (MY_IDX > ctrl.pos) begin
                    data_next = left_data;
                end else if (MY_IDX == ctrl.pos) begin
                    data_next = ins_value;
                end
            end
            OP_DEL: begin
                if (MY_IDX >= ctrl.pos) begin
                    data_next = right_data;
                end
            end
            OP_ROT: begin
                if (MY_IDX == ctrl.last) begin
                    data_next = head_data;
                end else if (MY_IDX < ctrl.last) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/core/ple_chain.sv */
`timescale 1ns / 1ps
`default_nettype none

module ple_chain #(
    parameter int CAPACITY = 32
) (
    input  wire logic                       aclk,
    input  wire ple_pkg::cell_ctrl_t        ctrl,
    input  wire logic [ple_pkg::DATA_W-1:0] ins_value,
    output logic [ple_pkg::DATA_W-1:0]      head_data
);
    import ple_pkg::*;

    logic [DATA_W-1:0] cell_data [CAPACITY];

    assign head_data = cell_data[0];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = ins_value;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        ple_cell #(
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .ins_value (ins_value),
            .left_data (left_d),
            .right_data(right_d),
            .head_data (cell_data[0]),
            .data      (cell_data[i])
        );
    end

endmodule

`default_nettype wire

/* rtl/core/positional_list_engine_top.sv */
// positional list engine
// keeps an ordered list of up to CAPACITY signed 32-bit entries in a row of
// cells; every cell shifts to its neighbor in parallel, so inserts and deletes
// take effect on the clock edge that accepts the command
// input channel s_*: one command per transfer (cmd, value, position)
// result channel m_*: registered outputs, one result per command, or one per
// entry for a read-out of a non-empty list, with m_last on the final one
// latency: the result appears the cycle after the command transfer
// throughput: while m_ready is high, inserts, deletes and ignored commands
// can follow every cycle and a read-out gives one entry per cycle, set by
// the rotation of the cell row through its head cell; no command is taken
// until the last result of a read-out has been transferred
// reset: aresetn is synchronous and active low; it empties the list and drops
// m_valid; cell contents are not cleared and are never read while unused
// stall: while m_valid is high and m_ready is low the result register holds,
// s_ready drops and the cell row holds, so nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine_top #(
    parameter int CAPACITY = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic signed [31:0] s_value,
    input  wire logic [5:0]         s_position,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_item,
    output logic [5:0]              m_item_index,
    output logic [5:0]              m_entry_count,
    output logic [1:0]              m_status,
    output logic                    m_last
);
    import ple_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    rd_reg, rd_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_item_reg, m_item_next;
    logic [5:0]       m_item_index_reg, m_item_index_next;
    logic [5:0]       m_entry_count_reg, m_entry_count_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             accept;
    logic             is_ins, is_del, is_read, bad;
    logic [POS_W-1:0] cp, pp, p;
    logic             emit_read;
    logic [CW-1:0]    rd_idx;
    logic [CW-1:0]    rd_inc;
    logic             rd_last;
    cell_ctrl_t       ctrl;
    logic [DATA_W-1:0] head_data;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign cp = POS_W'(count_reg);
    assign pp = POS_W'(s_position);

    always_comb begin
        is_ins  = 1'b0;
        is_del  = 1'b0;
        is_read = 1'b0;
        bad     = 1'b0;
        p       = '0;
        unique case (s_cmd)
            CMD_INS_FRONT: begin
                is_ins = 1'b1;
            end
            CMD_INS_BACK: begin
                is_ins = 1'b1;
                p      = cp;
            end
            CMD_INS_AT: begin
                is_ins = 1'b1;
                p      = pp - 1'b1;
                bad    = (pp == '0);
            end
            CMD_DEL_FRONT: begin
                is_del = 1'b1;
            end
            CMD_DEL_BACK: begin
                is_del = 1'b1;
                p      = cp - 1'b1;
                bad    = (cp == '0);
            end
            CMD_DEL_AT: begin
                is_del = 1'b1;
                p      = pp - 1'b1;
                bad    = (pp == '0);
            end
            CMD_READ: begin
                is_read = 1'b1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    assign rd_idx    = (state_reg == S_READ) ? rd_reg : '0;
    assign rd_inc    = CW'(rd_idx + 1'b1);
    assign rd_last   = (rd_inc == count_reg);
    assign emit_read = ((state_reg == S_READ) && out_free) ||
                       (accept && is_read && (count_reg != '0));

    always_comb begin
        state_next         = state_reg;
        count_next         = count_reg;
        rd_next            = rd_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_item_next        = m_item_reg;
        m_item_index_next  = m_item_index_reg;
        m_entry_count_next = m_entry_count_reg;
        m_status_next      = m_status_reg;
        m_last_next        = m_last_reg;
        ctrl.op            = OP_HOLD;
        ctrl.pos           = p;
        ctrl.last          = cp - 1'b1;

        if (emit_read) begin
            ctrl.op            = OP_ROT;
            m_valid_next       = 1'b1;
            m_item_next        = head_data;
            m_item_index_next  = 6'(rd_inc);
            m_entry_count_next = 6'(count_reg);
            m_status_next      = ST_DONE;
            m_last_next        = rd_last;
            rd_next            = rd_inc;
            state_next         = rd_last ? S_IDLE : S_READ;
        end else if (accept) begin
            m_valid_next       = 1'b1;
            m_item_next        = '0;
            m_item_index_next  = '0;
            m_last_next        = 1'b1;
            m_status_next      = ST_IGNORED;
            if (is_read) begin
                m_status_next = ST_EMPTY_READ;
            end else if (is_ins) begin
                if (bad || (p > cp)) begin
                    m_status_next = ST_IGNORED;
                end else if (cp >= CAP_P) begin
                    m_status_next = ST_FULL;
                end else begin
                    m_status_next = ST_DONE;
                    ctrl.op       = OP_INS;
                    count_next    = CW'(count_reg + 1'b1);
                end
            end else if (is_del) begin
                if (bad || (p >= cp)) begin
                    m_status_next = ST_IGNORED;
                end else begin
                    m_status_next = ST_DONE;
                    ctrl.op       = OP_DEL;
                    count_next    = CW'(count_reg - 1'b1);
                end
            end
            m_entry_count_next = 6'(count_next);
        end
    end

    ple_chain #(
        .CAPACITY(CAPACITY)
    ) u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .ins_value(s_value),
        .head_data(head_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_reg      <= rd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg        <= m_item_next;
        m_item_index_reg  <= m_item_index_next;
        m_entry_count_reg <= m_entry_count_next;
        m_status_reg      <= m_status_next;
        m_last_reg        <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_item        = m_item_reg;
    assign m_item_index  = m_item_index_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

/* rtl/core/ple_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ple_checker #(
    parameter int CAPACITY = 32
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [2:0]         s_cmd,
    input wire logic signed [31:0] s_value,
    input wire logic [5:0]         s_position,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_item,
    input wire logic [5:0]         m_item_index,
    input wire logic [5:0]         m_entry_count,
    input wire logic [1:0]         m_status,
    input wire logic               m_last
);
    import ple_pkg::*;

    localparam logic [5:0] CAP_6 = 6'(CAPACITY);

    logic unused_in;
    assign unused_in = s_valid ^ (^s_cmd) ^ (^s_value) ^ (^s_position);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item) && $stable(m_item_index)
            && $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> (m_entry_count == CAP_6))
        else $error("refused insert with list not full");

    a_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY_READ) |->
            (m_entry_count == 6'd0) && m_last && (m_item_index == 6'd0))
        else $error("bad empty read-out result");

    a_index_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_index != 6'd0) |-> (m_status == ST_DONE))
        else $error("read-out entry with non-done status");

    a_readout_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |-> !s_ready)
        else $error("command taken during read-out");

endmodule

bind positional_list_engine_top ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

`default_nettype wire

/* tb/tb_positional_list_engine_top.sv */
`timescale 1ns / 1ps

module tb_positional_list_engine_top;
    import ple_pkg::*;

    localparam int         LIST_CAP    = 32;
    localparam int         HOLD_CYCLES = 60;
    localparam logic [2:0] CMD_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [31:0] item;
        logic [5:0]  item_index;
        logic [5:0]  entry_count;
        logic [1:0]  status;
        logic        last;
    } list_result_t;

    class list_scoreboard;
        logic [31:0]  slots [LIST_CAP];
        int unsigned  held;
        list_result_t result_q [$];
        int unsigned  errors;
        int unsigned  cmds_taken;
        int unsigned  results_seen;
        int unsigned  read_outs;
        int unsigned  full_refusals;

        function new();
            held = 0;
            errors = 0;
            cmds_taken = 0;
            results_seen = 0;
            read_outs = 0;
            full_refusals = 0;
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

        function void push_result(logic [31:0] item, int unsigned idx, logic [1:0] st,
                                  logic last);
            list_result_t r;
            r.item = item;
            r.item_index = idx[5:0];
            r.entry_count = held[5:0];
            r.status = st;
            r.last = last;
            result_q.push_back(r);
        endfunction

        function void note_command(logic [2:0] cmd, logic [31:0] val, logic [5:0] pos);
            int unsigned slot;
            bit          is_ins;
            bit          is_del;
            logic [1:0]  st;
            slot = 0;
            is_ins = 0;
            is_del = 0;
            st = ST_IGNORED;
            cmds_taken++;
            case (cmd)
                CMD_INS_FRONT: begin
                    is_ins = 1;
                end
                CMD_INS_BACK: begin
                    is_ins = 1;
                    slot = held;
                end
                CMD_INS_AT: begin
                    is_ins = (pos != 0);
                    slot = pos - 1;
                end
                CMD_DEL_FRONT: begin
                    is_del = 1;
                end
                CMD_DEL_BACK: begin
                    is_del = (held != 0);
                    slot = held - 1;
                end
                CMD_DEL_AT: begin
                    is_del = (pos != 0);
                    slot = pos - 1;
                end
                CMD_READ: begin
                    read_outs++;
                    if (held == 0) begin
                        push_result(32'd0, 0, ST_EMPTY_READ, 1'b1);
                    end else begin
                        for (int i = 0; i < held; i++)
                            push_result(slots[i], i + 1, ST_DONE, (i + 1 == held));
                    end
                    return;
                end
                default: ;
            endcase
            if (is_ins) begin
                if (slot > held) begin
                    st = ST_IGNORED;
                end else if (held >= LIST_CAP) begin
                    st = ST_FULL;
                    full_refusals++;
                end else begin
                    for (int i = held; i > slot; i--)
                        slots[i] = slots[i - 1];
                    slots[slot] = val;
                    held++;
                    st = ST_DONE;
                end
            end else if (is_del) begin
                if (held == 0 || slot >= held) begin
                    st = ST_IGNORED;
                end else begin
                    for (int i = slot; i + 1 < held; i++)
                        slots[i] = slots[i + 1];
                    held--;
                    st = ST_DONE;
                end
            end
            push_result(32'd0, 0, st, 1'b1);
        endfunction

        function void check_result(list_result_t got);
            list_result_t exp;
            results_seen++;
            if (result_q.size() == 0) begin
                $error("result with nothing pending: item %0d count %0d status %0d",
                       $signed(got.item), got.entry_count, got.status);
                errors++;
                return;
            end
            exp = result_q.pop_front();
            if (got.item !== exp.item) begin
                $error("m_item: expected %0d, got %0d", $signed(exp.item), $signed(got.item));
                errors++;
            end
            if (got.item_index !== exp.item_index) begin
                $error("m_item_index: expected %0d, got %0d", exp.item_index, got.item_index);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("m_entry_count: expected %0d, got %0d", exp.entry_count,
                       got.entry_count);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("m_status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("m_last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic signed [31:0] s_value;
    logic [5:0]         s_position;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_item;
    logic [5:0]         m_item_index;
    logic [5:0]         m_entry_count;
    logic [1:0]         m_status;
    logic               m_last;

    bit             s_idle_en;
    bit             m_idle_en;
    bit             hold_req;
    list_scoreboard sb;

    positional_list_engine_top #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_value(s_value),
        .s_position(s_position),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item),
        .m_item_index(m_item_index),
        .m_entry_count(m_entry_count),
        .m_status(m_status),
        .m_last(m_last)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_item, m_item_index, m_entry_count, m_status, m_last});
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (m_idle_en && $urandom_range(0, 99) < 14) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_cmd(input logic [2:0] c, input logic [31:0] v, input logic [5:0] p);
        while (s_idle_en && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= c;
        s_value    <= v;
        s_position <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(c, v, p);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int ins_pct);
        int          r;
        int unsigned cnt;
        logic [2:0]  c;
        logic [5:0]  p;
        cnt = sb.held;
        r = $urandom_range(0, 99);
        if (r < 6)
            c = CMD_READ;
        else if (r < 8)
            c = CMD_UNKNOWN;
        else if (r < 8 + ins_pct)
            c = 3'($urandom_range(0, 2));
        else
            c = 3'($urandom_range(3, 5));
        if ($urandom_range(0, 4) == 0)
            p = 6'($urandom_range(0, 63));
        else if (c == CMD_DEL_AT)
            p = (cnt == 0) ? 6'd0 : 6'($urandom_range(1, cnt));
        else
            p = 6'($urandom_range(1, cnt + 1));
        send_cmd(c, pick_value(), p);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    initial begin
        int guard;
        sb = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_cmd      = CMD_INS_FRONT;
        s_value    = '0;
        s_position = '0;
        s_idle_en  = 1'b1;
        m_idle_en  = 1'b1;
        hold_req   = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list corner cases, then edge positions on a short list
        send_cmd(CMD_READ, 32'd0, 6'd0);
        send_cmd(CMD_DEL_FRONT, 32'd0, 6'd0);
        send_cmd(CMD_DEL_BACK, 32'd0, 6'd0);
        send_cmd(CMD_DEL_AT, 32'd0, 6'd1);
        send_cmd(CMD_DEL_AT, 32'd0, 6'd0);
        send_cmd(CMD_INS_AT, 32'd5, 6'd0);
        send_cmd(CMD_INS_AT, 32'd6, 6'd2);
        send_cmd(CMD_INS_AT, 32'h8000_0000, 6'd1);
        send_cmd(CMD_INS_BACK, 32'h7fff_ffff, 6'd63);
        send_cmd(CMD_INS_AT, 32'hffff_ffff, 6'd3);
        send_cmd(CMD_INS_FRONT, 32'h0000_0000, 6'd0);
        send_cmd(CMD_INS_AT, 32'h5555_aaaa, 6'd2);
        send_cmd(CMD_INS_AT, 32'haaaa_5555, 6'd63);
        send_cmd(CMD_READ, 32'hffff_ffff, 6'h3f);
        send_cmd(CMD_DEL_AT, 32'd0, 6'd63);
        send_cmd(CMD_DEL_AT, 32'd0, 6'd6);
        send_cmd(CMD_DEL_AT, 32'd0, 6'd2);
        send_cmd(CMD_DEL_BACK, 32'd0, 6'd0);
        send_cmd(CMD_DEL_FRONT, 32'd0, 6'd0);
        send_cmd(CMD_UNKNOWN, 32'h1234_5678, 6'd1);
        send_cmd(CMD_READ, 32'd0, 6'd0);

        for (int i = 0; i < 20; i++)
            send_random(55);

        // long result-side hold-off while commands keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_random(60);

        s_valid <= 1'b0;
        wait_drained();
        @(negedge aclk);

        // back-to-back stretch that fills the list to capacity
        s_idle_en = 1'b0;
        m_idle_en = 1'b0;
        for (int i = 0; i < 25; i++)
            send_random(85);
        while (sb.held < LIST_CAP)
            send_cmd(3'($urandom_range(0, 2)), pick_value(),
                     6'($urandom_range(1, sb.held + 1)));
        send_cmd(CMD_INS_FRONT, pick_value(), 6'd0);
        send_cmd(CMD_INS_BACK, pick_value(), 6'd0);
        send_cmd(CMD_INS_AT, pick_value(), 6'd33);
        send_cmd(CMD_INS_AT, pick_value(), 6'd40);
        send_cmd(CMD_READ, 32'd0, 6'd0);
        s_idle_en = 1'b1;
        m_idle_en = 1'b1;
        send_cmd(CMD_DEL_AT, 32'd0, 6'd32);
        send_cmd(CMD_READ, 32'd0, 6'd0);

        for (int i = 0; i < 15; i++)
            send_random(30);
        for (int i = 0; i < 10; i++)
            send_random(10);
        send_cmd(CMD_READ, 32'd0, 6'd0);

        s_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 100_000) begin
            @(negedge aclk);
            guard++;
        end
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        repeat (10) @(negedge aclk);

        $display("run covered %0d commands and %0d results: %0d read-outs, %0d full refusals",
                 sb.cmds_taken, sb.results_seen, sb.read_outs, sb.full_refusals);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/ple_chain.sv
rtl/core/positional_list_engine_top.sv
rtl/core/ple_checker.sv
tb/tb_positional_list_engine_top.sv
